// ===== rtl/core/ntcavg_pkg.sv =====
package ntcavg_pkg;

   // Field and datapath widths.
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned TEMP_W     = 15;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned NUM_W      = 20;
   localparam int unsigned DEN_W      = 19;
   localparam int unsigned RATIO_W    = 24;
   localparam int unsigned DIV_W      = 53;
   localparam int unsigned REM_W      = 40;
   localparam int unsigned DIVCNT_W   = 6;
   localparam int unsigned ACC_W      = 24;
   localparam int unsigned PAIR_W     = 16;
   localparam int unsigned LN_W       = 22;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 17;

   // Fixed-point constants.
   localparam logic signed [LN_W-1:0]   LN2_Q16  = 22'sd45426;
   localparam logic signed [24:0]       OUT_MIN  = -25'sd5500;
   localparam logic signed [24:0]       OUT_MAX  = 25'sd15000;
   localparam logic signed [PAIR_W-1:0] PAIR_MAX = 16'sh7FFF;
   localparam logic signed [PAIR_W-1:0] PAIR_MIN = 16'sh8000;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BETA   = 8'd0,
      CSR_TREF   = 8'd1,
      CSR_ZERO   = 8'd2,
      CSR_OFFSET = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [13:0] beta;
      logic [15:0] tref;
      logic [15:0] zero;
      logic [16:0] offset;
   } cfg_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      logic             bad;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } entry_type;

   // Q16 table of ln(1 + k/16).
   function automatic logic [15:0] ln_entry(input logic [4:0] k);
      logic [15:0] v;
      unique case (k)
         5'd0:    v = 16'd0;
         5'd1:    v = 16'd3973;
         5'd2:    v = 16'd7719;
         5'd3:    v = 16'd11262;
         5'd4:    v = 16'd14624;
         5'd5:    v = 16'd17821;
         5'd6:    v = 16'd20870;
         5'd7:    v = 16'd23783;
         5'd8:    v = 16'd26573;
         5'd9:    v = 16'd29248;
         5'd10:   v = 16'd31818;
         5'd11:   v = 16'd34292;
         5'd12:   v = 16'd36675;
         5'd13:   v = 16'd38975;
         5'd14:   v = 16'd41196;
         5'd15:   v = 16'd43345;
         5'd16:   v = 16'd45426;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/ntcavg_ifs.sv =====
interface ntcavg_req_if import ntcavg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] ntc_sample;
   logic [SAMPLE_W-1:0] ref_sample;
   modport source (output valid, ntc_sample, ref_sample, input ready);
   modport sink (input valid, ntc_sample, ref_sample, output ready);
endinterface

interface ntcavg_rsp_if import ntcavg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centi_c;
   logic                     range_error;
   modport source (output valid, temperature_centi_c, range_error, input ready);
   modport sink (input valid, temperature_centi_c, range_error, output ready);
endinterface

interface ntcavg_csr_if import ntcavg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ntcavg_front.sv =====
module ntcavg_front import ntcavg_pkg::*; (
   input  cfg_type           cfg,
   ntcavg_req_if.sink        req_chan,
   input  logic              queue_full,
   output logic              push,
   output entry_type         entry
);

   logic [SAMPLE_W-1:0] diff;

   // Take a request whenever the queue has room.
   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // Classify the pair and scale both sides of the resistance ratio.
   assign diff      = req_chan.ref_sample - req_chan.ntc_sample;
   assign entry.bad = (req_chan.ref_sample <= req_chan.ntc_sample);
   assign entry.num = NUM_W'(req_chan.ntc_sample) * NUM_W'(100) + NUM_W'(cfg.offset);
   assign entry.den = DEN_W'(diff) * DEN_W'(100);

endmodule

// ===== rtl/core/ntcavg_queue.sv =====
module ntcavg_queue import ntcavg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/ntcavg_back.sv =====
module ntcavg_back import ntcavg_pkg::*; #(
   parameter int unsigned SAMPLES = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       queue_empty,
   input  entry_type  head,
   output logic       pop,
   ntcavg_rsp_if.source rsp_chan
);

   // Reciprocal of the window length; exact for every 24-bit magnitude.
   localparam logic [28:0] MEAN_RECIP = 29'((2**28 + SAMPLES - 1) / SAMPLES);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_RDIV   = 14'b00000000000010,
      ST_RCLAMP = 14'b00000000000100,
      ST_NORM   = 14'b00000000001000,
      ST_LNMUL  = 14'b00000000010000,
      ST_LNSUM  = 14'b00000000100000,
      ST_TMUL   = 14'b00000001000000,
      ST_TLOAD  = 14'b00000010000000,
      ST_TDIV   = 14'b00000100000000,
      ST_TCONV  = 14'b00001000000000,
      ST_ACC    = 14'b00010000000000,
      ST_COUNT  = 14'b00100000000000,
      ST_MDIV   = 14'b01000000000000,
      ST_EMIT   = 14'b10000000000000
   } state_type;

   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   logic                     err_ff, err_in;

   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [REM_W-1:0]         divisor_ff, divisor_in;
   logic [DIVCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic [RATIO_W-1:0]       norm_ff, norm_in;
   logic [4:0]               p_ff, p_in;
   logic [16:0]              lnm_ff, lnm_in;
   logic signed [LN_W-1:0]   l_ff, l_in;
   logic [29:0]              tb_ff, tb_in;
   logic signed [38:0]       tl_ff, tl_in;
   logic signed [PAIR_W-1:0] pair_ff, pair_in;
   logic                     mneg_ff, mneg_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic                     rerr_ff, rerr_in;

   logic [REM_W-1:0]         rem_shift, rem_sub;
   logic                     rem_ge, div_last, slot_free;
   logic [3:0]               ln_k;
   logic [18:0]              ln_r;
   logic [15:0]              ln_base, ln_next;
   logic [11:0]              ln_diff;
   logic [30:0]              ln_prod;
   logic signed [5:0]        p_signed;
   logic [36:0]              tnum;
   logic [20:0]              bk;
   logic signed [REM_W-1:0]  tden;
   logic signed [54:0]       cdiff;
   logic [ACC_W-1:0]         mag;
   logic [52:0]              mean_prod;
   logic signed [24:0]       mean;

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.temperature_centi_c = temp_ff;
   assign rsp_chan.range_error         = rerr_ff;

   // One restoring step of the shared divider.
   assign rem_shift = {rem_ff[REM_W-2:0], quo_ff[DIV_W-1]};
   assign rem_ge    = (rem_shift >= divisor_ff);
   assign rem_sub   = rem_shift - divisor_ff;
   assign div_last  = (dcnt_ff == DIVCNT_W'(DIV_W - 1));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Log interpolation terms from the normalized ratio.
   assign ln_k     = norm_ff[22:19];
   assign ln_r     = norm_ff[18:0];
   assign ln_base  = ln_entry({1'b0, ln_k});
   assign ln_next  = ln_entry({1'b0, ln_k} + 5'd1);
   assign ln_diff  = 12'(ln_next - ln_base);
   assign ln_prod  = 31'(ln_diff) * 31'(ln_r);
   assign p_signed = $signed({1'b0, p_ff}) - 6'sd16;

   // Beta equation operands.
   assign tnum  = 37'(tb_ff) * 37'd100;
   assign bk    = 21'(cfg.beta) * 21'd100;
   assign tden  = $signed({3'b0, bk, 16'h0}) + REM_W'(tl_ff);
   assign cdiff = $signed({2'b0, quo_ff}) - $signed({39'b0, cfg.zero});
   assign mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;

   // Window mean magnitude by reciprocal multiplication.
   assign mean_prod = 53'(quo_ff[23:0]) * 53'(MEAN_RECIP);
   assign mean  = mneg_ff ? -$signed({1'b0, quo_ff[23:0]}) : $signed({1'b0, quo_ff[23:0]});

   // Sequencer for one pair, and the window mean at its end.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      dcnt_in      = dcnt_ff;
      norm_in      = norm_ff;
      p_in         = p_ff;
      lnm_in       = lnm_ff;
      l_in         = l_ff;
      tb_in        = tb_ff;
      tl_in        = tl_ff;
      pair_in      = pair_ff;
      mneg_in      = mneg_ff;
      temp_in      = temp_ff;
      rerr_in      = rerr_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head.bad) begin
                  err_in   = 1'b1;
                  state_in = ST_COUNT;
               end else begin
                  quo_in     = DIV_W'({head.num, 16'h0});
                  rem_in     = '0;
                  divisor_in = REM_W'(head.den);
                  dcnt_in    = '0;
                  state_in   = ST_RDIV;
               end
            end
         end
         ST_RDIV, ST_TDIV: begin
            quo_in  = {quo_ff[DIV_W-2:0], rem_ge};
            rem_in  = rem_ge ? rem_sub : rem_shift;
            dcnt_in = dcnt_ff + 1'b1;
            if (div_last) begin
               if (state_ff == ST_RDIV) begin
                  state_in = ST_RCLAMP;
               end else begin
                  state_in = ST_TCONV;
               end
            end
         end
         ST_RCLAMP: begin
            // Clamp the ratio to the Q8.16 code range.
            if (|quo_ff[DIV_W-1:RATIO_W]) begin
               norm_in = '1;
            end else if (quo_ff[RATIO_W-1:0] == '0) begin
               norm_in = RATIO_W'(1);
            end else begin
               norm_in = quo_ff[RATIO_W-1:0];
            end
            p_in     = 5'd23;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (norm_ff[RATIO_W-1] || (p_ff == 5'd0)) begin
               state_in = ST_LNMUL;
            end else begin
               norm_in = {norm_ff[RATIO_W-2:0], 1'b0};
               p_in    = p_ff - 5'd1;
            end
         end
         ST_LNMUL: begin
            lnm_in   = 17'(ln_base) + 17'(ln_prod[30:19]);
            state_in = ST_LNSUM;
         end
         ST_LNSUM: begin
            l_in     = LN_W'(p_signed) * LN2_Q16 + $signed({5'b0, lnm_ff});
            state_in = ST_TMUL;
         end
         ST_TMUL: begin
            tb_in    = 30'(cfg.beta) * 30'(cfg.tref);
            tl_in    = $signed({23'b0, cfg.tref}) * 39'(l_ff);
            state_in = ST_TLOAD;
         end
         ST_TLOAD: begin
            // A denominator at or below zero means a temperature past infinity.
            if (tden <= 0) begin
               pair_in  = PAIR_MAX;
               state_in = ST_ACC;
            end else begin
               quo_in     = {tnum, 16'h0};
               rem_in     = '0;
               divisor_in = REM_W'(tden);
               dcnt_in    = '0;
               state_in   = ST_TDIV;
            end
         end
         ST_TCONV: begin
            if (cdiff > 55'sd32767) begin
               pair_in = PAIR_MAX;
            end else if (cdiff < -55'sd32768) begin
               pair_in = PAIR_MIN;
            end else begin
               pair_in = cdiff[PAIR_W-1:0];
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + ACC_W'(pair_ff);
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if ((cnt_ff + 1'b1) == COUNT_W'(SAMPLES)) begin
               mneg_in  = acc_ff[ACC_W-1];
               quo_in   = DIV_W'(mag);
               state_in = ST_MDIV;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MDIV: begin
            quo_in   = DIV_W'(mean_prod[52:28]);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               if (mean < OUT_MIN) begin
                  temp_in = TEMP_W'(OUT_MIN);
               end else if (mean > OUT_MAX) begin
                  temp_in = TEMP_W'(OUT_MAX);
               end else begin
                  temp_in = mean[TEMP_W-1:0];
               end
               rerr_in      = err_ff;
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               cnt_in       = '0;
               err_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      dcnt_ff    <= dcnt_in;
      norm_ff    <= norm_in;
      p_ff       <= p_in;
      lnm_ff     <= lnm_in;
      l_ff       <= l_in;
      tb_ff      <= tb_in;
      tl_ff      <= tl_in;
      pair_ff    <= pair_in;
      mneg_ff    <= mneg_in;
      temp_ff    <= temp_in;
      rerr_ff    <= rerr_in;
   end

`ifndef SYNTHESIS
   // The window count never reaches the window length between requests.
   assert property (@(posedge clock) disable iff (reset) cnt_ff < COUNT_W'(SAMPLES))
      else $error("window count out of range");

   // The log step only starts on a normalized ratio.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LNMUL) |-> (norm_ff[RATIO_W-1] || (p_ff == 5'd0)))
      else $error("ratio not normalized");

   // Emitting a mean clears the window and presents the result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free) |=>
      (acc_ff == '0 && cnt_ff == '0 && !err_ff && rsp_valid_ff))
      else $error("window not cleared on emit");
`endif

endmodule

// ===== rtl/core/ntc_temperature_averager_top.sv =====
// Channel   | Direction | Payload
// req_chan  | in        | ntc_sample[11:0], ref_sample[11:0]
// rsp_chan  | out       | temperature_centi_c[14:0] signed, range_error
// csr_chan  | in        | index[7:0], data[16:0]
//
// A valid pair in the back end runs two 53-step divider passes with log
// normalization between them, or only the first pass if the beta denominator is
// not positive. A pair whose reference does not exceed its sample skips the ratio,
// log and beta steps, and the last pair of a window adds the mean multiply and emit.
// Reset is synchronous and active high; it restores the register defaults.
// A two-entry queue takes requests while the back end works; the result register
// lets the back end continue while a response stalls.
module ntc_temperature_averager_top import ntcavg_pkg::*; #(
   parameter int unsigned SAMPLES = 10
) (
   input logic          clock,
   input logic          reset,
   ntcavg_req_if.sink   req_chan,
   ntcavg_rsp_if.source rsp_chan,
   ntcavg_csr_if.sink   csr_chan
);

   cfg_type   cfg_ff, cfg_in;
   logic      push, pop, queue_full, queue_empty;
   entry_type push_entry, head;

   // Configuration registers; writes beyond the list are dropped.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_BETA:   cfg_in.beta   = csr_chan.data[13:0];
            CSR_TREF:   cfg_in.tref   = csr_chan.data[15:0];
            CSR_ZERO:   cfg_in.zero   = csr_chan.data[15:0];
            CSR_OFFSET: cfg_in.offset = csr_chan.data[16:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beta   <= 14'd4250;
         cfg_ff.tref   <= 16'd29815;
         cfg_ff.zero   <= 16'd27315;
         cfg_ff.offset <= 17'd21854;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept and classify requests.
   ntcavg_front u_front (
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   // Queue between the two halves.
   ntcavg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   // Back end: ratio, log, beta equation and window mean.
   ntcavg_back #(
      .SAMPLES (SAMPLES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
